/* design/mxt_pkg.sv */
// ----------------------------------------------------------------------------
// mxt_pkg: shared types and constants for the max-xor trie multiset
// Node word layout, widths, op codes and status codes.
// ----------------------------------------------------------------------------
package mxt_pkg;

  localparam int KEY_BITS   = 30;
  localparam int POOL_NODES = 65536;
  localparam int NODE_W     = $clog2(POOL_NODES);
  localparam int FREE_W     = NODE_W + 1;
  localparam int TALLY_W    = 20;
  localparam int LVL_W      = $clog2(KEY_BITS);

  localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

  // op codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_FULL   = 3'd1;
  localparam logic [2:0] ST_LIMIT  = 3'd2;
  localparam logic [2:0] ST_ABSENT = 3'd3;
  localparam logic [2:0] ST_EMPTY  = 3'd4;

  // one trie node
  typedef struct packed {
    logic [TALLY_W-1:0] tally;
    logic [NODE_W-1:0]  one_link;
    logic [NODE_W-1:0]  zero_link;
  } node_t;

  // write request into the node pool
  typedef struct packed {
    logic              en;
    logic [NODE_W-1:0] addr;
    node_t             data;
  } node_wr_t;

endpackage

/* design/mxt_mem.sv */
// ----------------------------------------------------------------------------
// mxt_mem: node pool memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mxt_mem (
  input  logic                      clk,
  input  mxt_pkg::node_wr_t         wr,
  input  logic [mxt_pkg::NODE_W-1:0] rd_addr,
  output mxt_pkg::node_t            rd_data
);

  mxt_pkg::node_t mem [mxt_pkg::POOL_NODES];

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

/* design/max_xor_trie_multiset.sv */
// ----------------------------------------------------------------------------
// max_xor_trie_multiset: multiset of keys in a bit trie, max-xor queries
// Sequencer that walks the trie held in the node pool memory.
// ----------------------------------------------------------------------------
// Insert and remove make a check pass and then an update pass over the trie,
// ending early when rejected or when the key is absent; a query makes one pass
// (ending at the root on an empty set), probing the opposite child where it exists.
// Throughput: one word at a time; the next word is taken once the result is in
// the output register.
// Reset: a clearing pass writes all POOL_NODES entries, building the chain
// for key zero; no word is accepted until it finishes.
// ----------------------------------------------------------------------------
module max_xor_trie_multiset (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [29:0] key,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [29:0] xor_result,
  output logic [2:0]  status
);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_WALK  = 4'd2;
  localparam logic [3:0] S_LEAF  = 4'd3;
  localparam logic [3:0] S_CHECK = 4'd4;
  localparam logic [3:0] S_UPD   = 4'd5;
  localparam logic [3:0] S_ULEAF = 4'd6;
  localparam logic [3:0] S_QNODE = 4'd7;
  localparam logic [3:0] S_QPRB  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  localparam logic [mxt_pkg::LVL_W-1:0] TOP_LVL = mxt_pkg::LVL_W'(mxt_pkg::KEY_BITS - 1);

  logic [3:0]                     state, state_next;
  logic [mxt_pkg::NODE_W-1:0]     clr_idx;
  logic [mxt_pkg::NODE_W-1:0]     cur, rd_addr;
  logic [mxt_pkg::NODE_W-1:0]     alt, alt_next;
  logic [mxt_pkg::LVL_W-1:0]      lvl, lvl_next;
  logic [mxt_pkg::FREE_W-1:0]     free, free_next;
  logic [mxt_pkg::LVL_W:0]        needed, needed_next;
  logic [mxt_pkg::TALLY_W-1:0]    root_tally, root_tally_next;
  logic [1:0]                     op_q;
  logic [29:0]                    key_q;
  logic [29:0]                    acc, acc_next;
  logic [2:0]                     st, st_next;
  mxt_pkg::node_t                 rd_data, wword;
  mxt_pkg::node_wr_t              wr;
  logic                           dir;
  logic [mxt_pkg::NODE_W-1:0]     child, other;
  logic                           accept;

  mxt_mem u_mem (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign dir      = key_q[lvl];
  assign child    = dir ? rd_data.one_link : rd_data.zero_link;
  assign other    = dir ? rd_data.zero_link : rd_data.one_link;

  // reset content of one pool entry: chain for key zero
  always_comb begin
    wword.one_link  = '0;
    wword.zero_link = (clr_idx < mxt_pkg::NODE_W'(mxt_pkg::KEY_BITS)) ?
                      clr_idx + 1'b1 : '0;
    wword.tally     = (clr_idx <= mxt_pkg::NODE_W'(mxt_pkg::KEY_BITS)) ?
                      mxt_pkg::TALLY_W'(1) : '0;
  end

  // sequencer
  always_comb begin
    state_next      = state;
    rd_addr         = cur;
    alt_next        = alt;
    lvl_next        = lvl;
    free_next       = free;
    needed_next     = needed;
    root_tally_next = root_tally;
    acc_next        = acc;
    st_next         = st;
    wr.en           = 1'b0;
    wr.addr         = cur;
    wr.data         = rd_data;

    unique case (state)
      S_CLR: begin
        wr.en   = 1'b1;
        wr.addr = clr_idx;
        wr.data = wword;
        if (clr_idx == {mxt_pkg::NODE_W{1'b1}}) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          rd_addr  = '0;
          lvl_next = TOP_LVL;
          acc_next = '0;
          st_next  = mxt_pkg::ST_OK;
          case (op)
            mxt_pkg::OP_INSERT, mxt_pkg::OP_REMOVE: state_next = S_WALK;
            mxt_pkg::OP_QUERY:                      state_next = S_QNODE;
            default:                                state_next = S_DONE;
          endcase
        end
      end
      // check pass: follow the key's path
      S_WALK: begin
        if (lvl == TOP_LVL) begin
          root_tally_next = rd_data.tally;
        end
        if (child == '0) begin
          if (op_q == mxt_pkg::OP_INSERT) begin
            needed_next = {1'b0, lvl} + 1'b1;
            state_next  = S_CHECK;
          end else begin
            st_next    = mxt_pkg::ST_ABSENT;
            state_next = S_DONE;
          end
        end else if (lvl == '0) begin
          if (op_q == mxt_pkg::OP_INSERT) begin
            needed_next = '0;
            state_next  = S_CHECK;
          end else begin
            rd_addr    = child;
            state_next = S_LEAF;
          end
        end else begin
          rd_addr  = child;
          lvl_next = lvl - 1'b1;
        end
      end
      S_LEAF: begin
        if (rd_data.tally == '0) begin
          st_next    = mxt_pkg::ST_ABSENT;
          state_next = S_DONE;
        end else begin
          rd_addr    = '0;
          lvl_next   = TOP_LVL;
          state_next = S_UPD;
        end
      end
      S_CHECK: begin
        if ((mxt_pkg::FREE_W+1)'(free) + (mxt_pkg::FREE_W+1)'(needed) >
            (mxt_pkg::FREE_W+1)'(mxt_pkg::POOL_NODES)) begin
          st_next    = mxt_pkg::ST_FULL;
          state_next = S_DONE;
        end else if (root_tally == mxt_pkg::TALLY_MAX) begin
          st_next    = mxt_pkg::ST_LIMIT;
          state_next = S_DONE;
        end else begin
          rd_addr    = '0;
          lvl_next   = TOP_LVL;
          state_next = S_UPD;
        end
      end
      // update pass: adjust tallies, allocate missing nodes on insert
      S_UPD: begin
        wr.en = 1'b1;
        if (op_q == mxt_pkg::OP_INSERT) begin
          wr.data.tally = rd_data.tally + 1'b1;
          if (child == '0) begin
            rd_addr   = free[mxt_pkg::NODE_W-1:0];
            free_next = free + 1'b1;
            if (dir) wr.data.one_link  = free[mxt_pkg::NODE_W-1:0];
            else     wr.data.zero_link = free[mxt_pkg::NODE_W-1:0];
          end else begin
            rd_addr = child;
          end
        end else begin
          wr.data.tally = rd_data.tally - 1'b1;
          rd_addr       = child;
        end
        if (lvl == '0) state_next = S_ULEAF;
        else           lvl_next   = lvl - 1'b1;
      end
      S_ULEAF: begin
        wr.en         = 1'b1;
        wr.data.tally = (op_q == mxt_pkg::OP_INSERT) ? rd_data.tally + 1'b1 :
                                                       rd_data.tally - 1'b1;
        state_next    = S_DONE;
      end
      // query: at a node, probe the child opposite to the key bit
      S_QNODE: begin
        if ((lvl == TOP_LVL) && (rd_data.tally == '0)) begin
          st_next    = mxt_pkg::ST_EMPTY;
          state_next = S_DONE;
        end else begin
          alt_next = child;
          if (other != '0) begin
            rd_addr    = other;
            state_next = S_QPRB;
          end else begin
            rd_addr = child;
            if (lvl == '0) state_next = S_DONE;
            else           lvl_next   = lvl - 1'b1;
          end
        end
      end
      S_QPRB: begin
        if (rd_data.tally != '0) begin
          acc_next[lvl] = 1'b1;
        end else begin
          rd_addr = alt;
        end
        if (lvl == '0) begin
          state_next = S_DONE;
        end else begin
          lvl_next   = lvl - 1'b1;
          state_next = S_QNODE;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_idx   <= '0;
      free      <= mxt_pkg::FREE_W'(mxt_pkg::KEY_BITS + 1);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      free  <= free_next;
      if (state == S_CLR) clr_idx <= clr_idx + 1'b1;
      if (state == S_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cur        <= rd_addr;
    alt        <= alt_next;
    lvl        <= lvl_next;
    needed     <= needed_next;
    root_tally <= root_tally_next;
    acc        <= acc_next;
    st         <= st_next;
    if (accept) begin
      op_q  <= op;
      key_q <= key;
    end
    if (state == S_DONE && (!out_valid || !out_stall)) begin
      status     <= st;
      xor_result <= (op_q == mxt_pkg::OP_QUERY && st == mxt_pkg::ST_OK) ? acc : '0;
    end
  end

endmodule
